@@ rtl/postfix_expression_evaluator_assert.svh @@
// ----------------------------------------------------------------------------
// Postfix expression evaluator assertion macros
// Shared concurrent assertion forms used by the evaluator RTL.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define PEE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("evaluator assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define PEE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("evaluator assertion failed: next-cycle implication");

// The condition must never be true.
`define PEE_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("evaluator assertion failed: forbidden condition");

`else

`define PEE_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PEE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define PEE_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

@@ rtl/pee_pkg.sv @@
// ----------------------------------------------------------------------------
// Postfix expression evaluator package
// Widths, token and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package pee_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int DATA_W      = 32;
    localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int DIV_CNT_W   = $clog2(DATA_W + 1);

    typedef enum logic [2:0] {
        FN_PUSH = 3'd0,
        FN_ADD  = 3'd1,
        FN_SUB  = 3'd2,
        FN_MUL  = 3'd3,
        FN_DIV  = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNDER   = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_OVER    = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_tok;
        logic    push;
        logic    rd;
        logic    alu_wr;
        logic    div_start;
        logic    div_wr;
        logic    err_wr;
        t_status err_code;
        logic    emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] fn;
        logic       last;
        logic       err_set;
        logic       lvl_empty;
        logic       lvl_lt2;
        logic       lvl_full;
        logic       b_zero;
        logic       div_done;
    } t_dp_status;

endpackage

@@ rtl/pee_tok_if.sv @@
// ----------------------------------------------------------------------------
// Token channel
// Valid/ready channel that carries one expression token per transaction.
// ----------------------------------------------------------------------------
interface pee_tok_if;
    logic                             valid;
    logic                             ready;
    logic [2:0]                       func;
    logic signed [pee_pkg::DATA_W-1:0] number;
    logic                             last_token;

    modport source (output valid, output func, output number, output last_token,
                    input ready);
    modport sink   (input valid, input func, input number, input last_token,
                    output ready);
endinterface

@@ rtl/pee_res_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one expression result per transaction.
// ----------------------------------------------------------------------------
interface pee_res_if;
    logic                             valid;
    logic                             ready;
    logic signed [pee_pkg::DATA_W-1:0] answer;
    logic [1:0]                       status;

    modport source (output valid, output answer, output status, input ready);
    modport sink   (input valid, input answer, input status, output ready);
endinterface

@@ rtl/postfix_expression_evaluator.sv @@
// ----------------------------------------------------------------------------
// Postfix expression evaluator
// Evaluates a reverse Polish integer expression arriving one token at a time.
// ----------------------------------------------------------------------------
// Each token transaction on i_tok carries a kind (push number, add, subtract,
// multiply or divide), a 32-bit signed number used only by pushes, and a flag
// that marks the final token of the expression. Arithmetic is 32-bit two's
// complement and wraps; division truncates toward zero. After the final token
// one transaction on o_res gives the top of the stack and a status (ok, stack
// underflow, divide by zero or stack overflow); the answer is zero whenever the
// status is not ok, and the stack and error state are then cleared for the next
// expression. Only the first error of an expression is reported, and tokens
// after it are skipped. Unknown kinds are skipped without error. Tokens are
// handled one at a time: a push or an ignored token goes through decode and
// finish, add, subtract and multiply also through an operand step, and a
// divide then waits while the bit-serial divider forms the quotient and
// hands it over. The operand stack memory has one read and one write port
// with a registered read, and the top entry is kept in a register so that an
// operator needs only one memory read. A finished result waits in an output
// register, so the next expression may start while it has not been taken; a
// second result stalls in the finish step until the first one is taken.
// The stack memory holds no reset value, as only written entries are read.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pee_tok_if.sink     i_tok,
    pee_res_if.source   o_res
);

    pee_pkg::t_dp_cmd               w_cmd;
    pee_pkg::t_dp_status            w_sts;
    logic                           w_tok_ready;
    logic                           w_res_valid;
    logic [pee_pkg::DATA_W-1:0]     w_answer;
    logic [1:0]                     w_status;

    // The controller owns the handshakes and sequences each token.
    pee_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (i_tok.valid),
        .o_tok_ready (w_tok_ready),
        .o_res_valid (w_res_valid),
        .i_res_ready (o_res.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the stack, the error latch and the result register.
    pee_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_func       (i_tok.func),
        .i_number     (i_tok.number),
        .i_last_token (i_tok.last_token),
        .o_sts        (w_sts),
        .o_answer     (w_answer),
        .o_status     (w_status)
    );

    assign i_tok.ready  = w_tok_ready;
    assign o_res.valid  = w_res_valid;
    assign o_res.answer = w_answer;
    assign o_res.status = w_status;

endmodule

@@ rtl/pee_div.sv @@
// ----------------------------------------------------------------------------
// Postfix evaluator divider
// Signed 32-bit restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module pee_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pee_pkg::DATA_W-1:0]  i_dividend,
    input  logic [pee_pkg::DATA_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [pee_pkg::DATA_W-1:0]  o_quot
);

    logic                           r_busy;
    logic                           r_done;
    logic [pee_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [pee_pkg::DATA_W-1:0]     r_rem;
    logic [pee_pkg::DATA_W-1:0]     r_quo;
    logic [pee_pkg::DATA_W-1:0]     r_den;
    logic                           r_neg;

    logic [pee_pkg::DATA_W:0]       w_shift;
    logic [pee_pkg::DATA_W:0]       w_diff;
    logic                           w_bit;

    assign w_shift = {r_rem, r_quo[pee_pkg::DATA_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_bit   = ~w_diff[pee_pkg::DATA_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == pee_pkg::DIV_CNT_W'(pee_pkg::DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + pee_pkg::DIV_CNT_W'(1);
            end
        end
    end

    // Operands are taken as magnitudes; the sign is applied at the output.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[pee_pkg::DATA_W-1] ? ('0 - i_dividend) : i_dividend;
            r_den <= i_divisor[pee_pkg::DATA_W-1] ? ('0 - i_divisor) : i_divisor;
            r_neg <= i_dividend[pee_pkg::DATA_W-1] ^ i_divisor[pee_pkg::DATA_W-1];
        end else if (r_busy) begin
            r_rem <= w_bit ? w_diff[pee_pkg::DATA_W-1:0] : w_shift[pee_pkg::DATA_W-1:0];
            r_quo <= {r_quo[pee_pkg::DATA_W-2:0], w_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? ('0 - r_quo) : r_quo;

endmodule

@@ rtl/pee_dp.sv @@
// ----------------------------------------------------------------------------
// Postfix evaluator datapath
// Token registers, operand stack memory, top-of-stack register, ALU, divider.
// ----------------------------------------------------------------------------
module pee_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pee_pkg::t_dp_cmd            i_cmd,
    input  logic [2:0]                  i_func,
    input  logic [pee_pkg::DATA_W-1:0]  i_number,
    input  logic                        i_last_token,
    output pee_pkg::t_dp_status         o_sts,
    output logic [pee_pkg::DATA_W-1:0]  o_answer,
    output logic [1:0]                  o_status
);

    // Stack entries below the top live in memory; the top lives in r_tos.
    logic [pee_pkg::DATA_W-1:0]     r_mem [pee_pkg::STACK_DEPTH];

    logic [2:0]                     r_fn;
    logic [pee_pkg::DATA_W-1:0]     r_num;
    logic                           r_last;
    logic [pee_pkg::LVL_W-1:0]      r_level;
    pee_pkg::t_status               r_err;
    logic [pee_pkg::DATA_W-1:0]     r_tos;
    logic [pee_pkg::DATA_W-1:0]     r_rd;
    logic [pee_pkg::DATA_W-1:0]     r_ans;
    pee_pkg::t_status               r_st;

    logic [pee_pkg::LVL_W-1:0]      w_lvl_m1;
    logic [pee_pkg::LVL_W-1:0]      w_lvl_m2;
    logic [pee_pkg::DATA_W-1:0]     w_alu;
    logic [pee_pkg::DATA_W-1:0]     w_quot;
    logic                           w_div_done;

    assign w_lvl_m1 = r_level - pee_pkg::LVL_W'(1);
    assign w_lvl_m2 = r_level - pee_pkg::LVL_W'(2);

    always_comb begin
        unique case (r_fn)
            pee_pkg::FN_ADD: w_alu = r_rd + r_tos;
            pee_pkg::FN_SUB: w_alu = r_rd - r_tos;
            default:         w_alu = r_rd * r_tos;
        endcase
    end

    pee_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_rd),
        .i_divisor  (r_tos),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && (r_level != '0)) begin
            r_mem[w_lvl_m1[pee_pkg::IDX_W-1:0]] <= r_tos;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[w_lvl_m2[pee_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_tok) begin
            r_fn   <= i_func;
            r_num  <= i_number;
            r_last <= i_last_token;
        end
        if (i_cmd.push) begin
            r_tos <= r_num;
        end else if (i_cmd.alu_wr) begin
            r_tos <= w_alu;
        end else if (i_cmd.div_wr) begin
            r_tos <= w_quot;
        end
        if (i_cmd.emit) begin
            if (r_err != pee_pkg::ST_OK) begin
                r_ans <= '0;
                r_st  <= r_err;
            end else if (r_level == '0) begin
                r_ans <= '0;
                r_st  <= pee_pkg::ST_UNDER;
            end else begin
                r_ans <= r_tos;
                r_st  <= pee_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_err   <= pee_pkg::ST_OK;
        end else begin
            if (i_cmd.emit) begin
                r_level <= '0;
                r_err   <= pee_pkg::ST_OK;
            end else begin
                if (i_cmd.push) begin
                    r_level <= r_level + pee_pkg::LVL_W'(1);
                end else if (i_cmd.alu_wr || i_cmd.div_wr) begin
                    r_level <= w_lvl_m1;
                end
                if (i_cmd.err_wr) begin
                    r_err <= i_cmd.err_code;
                end
            end
        end
    end

    assign o_sts.fn        = r_fn;
    assign o_sts.last      = r_last;
    assign o_sts.err_set   = (r_err != pee_pkg::ST_OK);
    assign o_sts.lvl_empty = (r_level == '0);
    assign o_sts.lvl_lt2   = (r_level < pee_pkg::LVL_W'(2));
    assign o_sts.lvl_full  = (r_level == pee_pkg::LVL_W'(pee_pkg::STACK_DEPTH));
    assign o_sts.b_zero    = (r_tos == '0);
    assign o_sts.div_done  = w_div_done;

    assign o_answer = r_ans;
    assign o_status = r_st;

endmodule

@@ rtl/pee_ctrl.sv @@
// ----------------------------------------------------------------------------
// Postfix evaluator controller
// Sequences each token through decode, operand fetch, execute and finish.
// ----------------------------------------------------------------------------
`include "postfix_expression_evaluator_assert.svh"

module pee_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_tok_valid,
    output logic                    o_tok_ready,
    output logic                    o_res_valid,
    input  logic                    i_res_ready,
    input  pee_pkg::t_dp_status     i_sts,
    output pee_pkg::t_dp_cmd        o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_OPER,
        S_DIV,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_tok_valid) begin
                    o_cmd.load_tok = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FIN;
                // Once an error is latched, tokens are skipped until the last one.
                if (!i_sts.err_set) begin
                    unique case (i_sts.fn)
                        pee_pkg::FN_PUSH: begin
                            if (i_sts.lvl_full) begin
                                o_cmd.err_wr   = 1'b1;
                                o_cmd.err_code = pee_pkg::ST_OVER;
                            end else begin
                                o_cmd.push = 1'b1;
                            end
                        end
                        pee_pkg::FN_ADD, pee_pkg::FN_SUB,
                        pee_pkg::FN_MUL, pee_pkg::FN_DIV: begin
                            if (i_sts.lvl_lt2) begin
                                o_cmd.err_wr   = 1'b1;
                                o_cmd.err_code = pee_pkg::ST_UNDER;
                            end else begin
                                o_cmd.rd = 1'b1;
                                n_state  = S_OPER;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_OPER: begin
                if (i_sts.fn == pee_pkg::FN_DIV) begin
                    if (i_sts.b_zero) begin
                        o_cmd.err_wr   = 1'b1;
                        o_cmd.err_code = pee_pkg::ST_DIVZERO;
                        n_state        = S_FIN;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                end else begin
                    o_cmd.alu_wr = 1'b1;
                    n_state      = S_FIN;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_wr = 1'b1;
                    n_state      = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_sts.last) begin
                    n_state = S_IDLE;
                end else if (!r_out_valid || i_res_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_tok_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;

    `PEE_ASSERT_NEVER(a_emit_over_pending, i_clk, i_rst_n, o_cmd.emit && r_out_valid && !i_res_ready)
    `PEE_ASSERT_NEXT(a_emit_clears_stack, i_clk, i_rst_n, o_cmd.emit, i_sts.lvl_empty && !i_sts.err_set)
    `PEE_ASSERT_NEVER(a_push_when_full, i_clk, i_rst_n, o_cmd.push && i_sts.lvl_full)
    `PEE_ASSERT_SAME(a_div_done_waited, i_clk, i_rst_n, o_cmd.div_wr, r_state == S_DIV && !i_sts.b_zero)

endmodule

@@ dv/postfix_expression_evaluator_tb.sv @@
// ----------------------------------------------------------------------------
// Postfix expression evaluator testbench
// Drives reverse Polish token streams into the evaluator and checks every
// result transaction against a cycle-free model of the operand stack or a typed-in expectation.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Kinds with no meaning to the block. They must be skipped without error.
    localparam logic [2:0] FN_SPARE5 = 3'd5;
    localparam logic [2:0] FN_SPARE6 = 3'd6;
    localparam logic [2:0] FN_SPARE7 = 3'd7;

    localparam logic signed [pee_pkg::DATA_W-1:0] NUM_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [pee_pkg::DATA_W-1:0] NUM_MIN = 32'sh8000_0000;

    // A divide is the slowest token, and this covers any work
    // still in flight once the last answer has been seen.
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_TOKENS = 1050;

    typedef struct packed {
        logic signed [pee_pkg::DATA_W-1:0] answer;
        pee_pkg::t_status                  status;
    } t_expr_result;

    // One row of the directed table. Where typed is set, the answer and
    // status given in the row are the expectation; elsewhere the stack model
    // supplies it.
    typedef struct packed {
        logic [2:0]                        func;
        logic signed [pee_pkg::DATA_W-1:0] number;
        logic                              last_token;
        logic                              typed;
        logic signed [pee_pkg::DATA_W-1:0] answer;
        pee_pkg::t_status                  status;
    } t_token_row;

    logic i_clk;
    logic i_rst_n;

    pee_tok_if tok_if();
    pee_res_if res_if();

    postfix_expression_evaluator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (tok_if),
        .o_res   (res_if)
    );

    // ------------------------------------------------------------------------
    // Clock, reset and the overall time limit.
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // The slowest legal run, including both sides' stalls, is far below this.
    initial begin
        #(20_000_000);
        $display("[postfix_expression_evaluator] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stack model. It mirrors the operand stack, its level and the first
    // error of the expression, and is advanced once per accepted token.
    // ------------------------------------------------------------------------
    logic signed [pee_pkg::DATA_W-1:0] shadow_stack [pee_pkg::STACK_DEPTH];
    int unsigned                       shadow_level = 0;
    pee_pkg::t_status                  shadow_err   = pee_pkg::ST_OK;

    t_expr_result pending_answers [$];
    int unsigned  failures = 0;

    // When set, neither side inserts stall cycles.
    bit calm = 1'b0;

    function automatic bit evaluate_token(input logic [2:0] fn,
                                          input logic signed [pee_pkg::DATA_W-1:0] num,
                                          input logic last,
                                          output t_expr_result res);
        logic [pee_pkg::DATA_W-1:0] a, b, r, ma, mb, q;
        bit                         writes_back;
        res         = '0;
        writes_back = 1'b0;
        r           = '0;
        if (shadow_err == pee_pkg::ST_OK) begin
            if (fn == pee_pkg::FN_PUSH) begin
                if (shadow_level >= pee_pkg::STACK_DEPTH) begin
                    shadow_err = pee_pkg::ST_OVER;
                end else begin
                    shadow_stack[shadow_level] = num;
                    shadow_level++;
                end
            end else if (fn >= pee_pkg::FN_ADD && fn <= pee_pkg::FN_DIV) begin
                if (shadow_level < 2) begin
                    shadow_err = pee_pkg::ST_UNDER;
                end else begin
                    // Left operand sits below the right one.
                    a           = shadow_stack[shadow_level - 2];
                    b           = shadow_stack[shadow_level - 1];
                    writes_back = 1'b1;
                    case (fn)
                        pee_pkg::FN_ADD: r = a + b;
                        pee_pkg::FN_SUB: r = a - b;
                        pee_pkg::FN_MUL: r = a * b;
                        default: begin
                            if (b == '0) begin
                                shadow_err  = pee_pkg::ST_DIVZERO;
                                writes_back = 1'b0;
                            end else begin
                                // Work on magnitudes so that truncation goes
                                // toward zero and the most negative value
                                // over minus one wraps back onto itself.
                                ma = a[pee_pkg::DATA_W-1] ? (32'd0 - a) : a;
                                mb = b[pee_pkg::DATA_W-1] ? (32'd0 - b) : b;
                                q  = ma / mb;
                                r  = (a[pee_pkg::DATA_W-1] ^ b[pee_pkg::DATA_W-1]) ?
                                     (32'd0 - q) : q;
                            end
                        end
                    endcase
                    if (writes_back) begin
                        shadow_stack[shadow_level - 2] = r;
                        shadow_level--;
                    end
                end
            end
        end
        if (!last) begin
            return 1'b0;
        end
        res.status = shadow_err;
        res.answer = '0;
        if (shadow_err == pee_pkg::ST_OK) begin
            if (shadow_level == 0) begin
                res.status = pee_pkg::ST_UNDER;
            end else begin
                res.answer = shadow_stack[shadow_level - 1];
            end
        end
        shadow_level = 0;
        shadow_err   = pee_pkg::ST_OK;
        return 1'b1;
    endfunction

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 17);
    endfunction

    // Operand values lean toward small numbers and the extremes so that
    // wraps, zero divisors and sign combinations come up often.
    function automatic logic signed [pee_pkg::DATA_W-1:0] pick_number();
        logic signed [pee_pkg::DATA_W-1:0] corners [5];
        int unsigned                       roll;
        corners = '{32'sd0, 32'sd1, -32'sd1, NUM_MIN, NUM_MAX};
        roll    = $urandom_range(99);
        if (roll < 30) begin
            return $signed($urandom_range(20)) - 32'sd10;
        end else if (roll < 42) begin
            return corners[$urandom_range(4)];
        end
        return $urandom;
    endfunction

    // ------------------------------------------------------------------------
    // Token side. Inputs change on the falling edge; a transaction is taken
    // at the rising edge where valid and ready are both high. The stack model
    // is advanced at that same edge, which is always earlier than the edge at
    // which the block can present the matching result.
    // ------------------------------------------------------------------------
    int unsigned random_sent = 0;

    task automatic send_token(input logic [2:0] fn,
                              input logic signed [pee_pkg::DATA_W-1:0] num,
                              input logic last, input logic typed,
                              input t_expr_result typed_res);
        t_expr_result predicted;
        bit           has_result;
        // Stall cycles carry garbage payload so that it is never relied upon.
        while (take_break()) begin
            tok_if.valid      <= 1'b0;
            tok_if.func       <= 3'($urandom);
            tok_if.number     <= $urandom;
            tok_if.last_token <= 1'($urandom);
            @(negedge i_clk);
        end
        tok_if.valid      <= 1'b1;
        tok_if.func       <= fn;
        tok_if.number     <= num;
        tok_if.last_token <= last;
        @(posedge i_clk);
        while (!tok_if.ready) @(posedge i_clk);
        has_result = evaluate_token(fn, num, last, predicted);
        if (has_result) begin
            pending_answers.push_back(typed ? typed_res : predicted);
        end
        @(negedge i_clk);
    endtask

    task automatic send_random(input logic [2:0] fn,
                               input logic signed [pee_pkg::DATA_W-1:0] num,
                               input logic last);
        send_token(fn, num, last, 1'b0, '0);
        random_sent++;
        // A long stretch in the middle of the random part runs without stalls.
        calm = (random_sent >= 350 && random_sent < 550);
    endtask

    // A well-formed expression with random shape and content. Pushes and
    // operators are interleaved at random, keeping at least two operands
    // below every operator, until one value remains.
    task automatic send_expression(input int unsigned operands);
        pee_pkg::t_func ops [4];
        int unsigned    pushes_left;
        int unsigned    depth;
        logic [2:0]     fn;
        logic           last;
        ops         = '{pee_pkg::FN_ADD, pee_pkg::FN_SUB, pee_pkg::FN_MUL, pee_pkg::FN_DIV};
        pushes_left = operands;
        depth       = 0;
        while (pushes_left > 0 || depth > 1) begin
            // Skipped kinds now and then; they must leave the stack alone.
            if ($urandom_range(19) == 0) begin
                send_random(3'($urandom_range(FN_SPARE7, FN_SPARE5)), pick_number(), 1'b0);
            end
            if (depth < 2 || (pushes_left > 0 && $urandom_range(1) == 1)) begin
                fn = pee_pkg::FN_PUSH;
                pushes_left--;
                depth++;
            end else begin
                fn = ops[$urandom_range(3)];
                depth--;
            end
            last = (pushes_left == 0 && depth == 1);
            send_random(fn, pick_number(), last);
        end
    endtask

    // Random kinds, including the skipped ones, in a short run. These hit
    // underflow on operators and at the last token, and errors mid-stream.
    task automatic send_noise();
        int unsigned len;
        len = $urandom_range(6, 1);
        for (int unsigned i = 0; i < len; i++) begin
            send_random(3'($urandom_range(7)), pick_number(), i == len - 1);
        end
    endtask

    // Fill the stack to its full depth. With spill set, one more push
    // overflows and the remaining tokens must be skipped; otherwise the stack
    // is reduced by one and refilled to full before the final operator.
    task automatic send_deep(input bit spill);
        for (int unsigned i = 0; i < pee_pkg::STACK_DEPTH; i++) begin
            send_random(pee_pkg::FN_PUSH, pick_number(), 1'b0);
        end
        if (spill) begin
            send_random(pee_pkg::FN_PUSH, pick_number(), 1'b0);
            send_random(pee_pkg::FN_SUB, pick_number(), 1'b0);
            send_random(pee_pkg::FN_PUSH, pick_number(), 1'b0);
            send_random(pee_pkg::FN_ADD, pick_number(), 1'b1);
        end else begin
            send_random(pee_pkg::FN_ADD, pick_number(), 1'b0);
            send_random(pee_pkg::FN_PUSH, pick_number(), 1'b0);
            send_random(pee_pkg::FN_MUL, pick_number(), 1'b1);
        end
    endtask

    // The directed table. Rows with an expected result typed in are those
    // whose answer is plain from the token sequence: an empty stack at the
    // last token, pushes of the extremes, the most negative value divided by
    // minus one, a divide by zero with tokens after it, too few operands,
    // a wrap on add, and leftover operands under the reported top.
    t_token_row directed_rows [25] = '{
        '{FN_SPARE5,        32'sd0,  1'b1, 1'b1, 32'sd0,  pee_pkg::ST_UNDER},
        '{pee_pkg::FN_PUSH, NUM_MAX, 1'b1, 1'b1, NUM_MAX, pee_pkg::ST_OK},
        '{pee_pkg::FN_PUSH, NUM_MIN, 1'b1, 1'b1, NUM_MIN, pee_pkg::ST_OK},
        '{pee_pkg::FN_PUSH, NUM_MIN, 1'b0, 1'b0, 32'sd0,  pee_pkg::ST_OK},
        '{pee_pkg::FN_PUSH, -32'sd1, 1'b0, 1'b0, 32'sd0,  pee_pkg::ST_OK},
        '{pee_pkg::FN_DIV,  32'sd0,  1'b1, 1'b1, NUM_MIN, pee_pkg::ST_OK},
        '{pee_pkg::FN_PUSH, 32'sd7,  1'b0, 1'b0, 32'sd0,  pee_pkg::ST_OK},
        '{pee_pkg::FN_PUSH, 32'sd0,  1'b0, 1'b0, 32'sd0,  pee_pkg::ST_OK},
        '{pee_pkg::FN_DIV,  32'sd0,  1'b0, 1'b0, 32'sd0,  pee_pkg::ST_OK},
        '{pee_pkg::FN_PUSH, 32'sd5,  1'b0, 1'b0, 32'sd0,  pee_pkg::ST_OK},
        '{pee_pkg::FN_ADD,  32'sd0,  1'b1, 1'b1, 32'sd0,  pee_pkg::ST_DIVZERO},
        '{pee_pkg::FN_PUSH, 32'sd1,  1'b0, 1'b0, 32'sd0,  pee_pkg::ST_OK},
        '{pee_pkg::FN_SUB,  32'sd0,  1'b1, 1'b1, 32'sd0,  pee_pkg::ST_UNDER},
        '{pee_pkg::FN_PUSH, -32'sd7, 1'b0, 1'b0, 32'sd0,  pee_pkg::ST_OK},
        '{pee_pkg::FN_PUSH, 32'sd2,  1'b0, 1'b0, 32'sd0,  pee_pkg::ST_OK},
        '{pee_pkg::FN_DIV,  32'sd0,  1'b0, 1'b0, 32'sd0,  pee_pkg::ST_OK},
        '{pee_pkg::FN_PUSH, 32'sd6,  1'b0, 1'b0, 32'sd0,  pee_pkg::ST_OK},
        '{FN_SPARE7,        -32'sd1, 1'b0, 1'b0, 32'sd0,  pee_pkg::ST_OK},
        '{pee_pkg::FN_MUL,  32'sd0,  1'b1, 1'b0, 32'sd0,  pee_pkg::ST_OK},
        '{pee_pkg::FN_PUSH, NUM_MAX, 1'b0, 1'b0, 32'sd0,  pee_pkg::ST_OK},
        '{pee_pkg::FN_PUSH, 32'sd1,  1'b0, 1'b0, 32'sd0,  pee_pkg::ST_OK},
        '{pee_pkg::FN_ADD,  32'sd0,  1'b1, 1'b1, NUM_MIN, pee_pkg::ST_OK},
        '{pee_pkg::FN_PUSH, 32'sd11, 1'b0, 1'b0, 32'sd0,  pee_pkg::ST_OK},
        '{FN_SPARE6,        32'sd3,  1'b0, 1'b0, 32'sd0,  pee_pkg::ST_OK},
        '{pee_pkg::FN_PUSH, NUM_MIN, 1'b1, 1'b1, NUM_MIN, pee_pkg::ST_OK}
    };

    initial begin
        int unsigned  roll;
        t_expr_result row_res;
        tok_if.valid      = 1'b0;
        tok_if.func       = pee_pkg::FN_PUSH;
        tok_if.number     = '0;
        tok_if.last_token = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            row_res.answer = directed_rows[i].answer;
            row_res.status = directed_rows[i].status;
            send_token(directed_rows[i].func, directed_rows[i].number,
                       directed_rows[i].last_token, directed_rows[i].typed, row_res);
        end

        // Most expressions are well formed and short; a few run deep, some
        // are noise, and in two stretches of the run the stack may be taken to
        // full depth, overflowing in the second one.
        while (random_sent < RANDOM_TOKENS) begin
            roll = $urandom_range(99);
            if (random_sent > 150 && random_sent < 400 && shadow_level == 0 && roll < 3) begin
                send_deep(1'b0);
            end else if (random_sent > 600 && random_sent < 800 && roll < 3) begin
                send_deep(1'b1);
            end else if (roll < 18) begin
                send_noise();
            end else if (roll < 30) begin
                send_expression($urandom_range(40, 7));
            end else begin
                send_expression($urandom_range(6, 1));
            end
        end
        tok_if.valid <= 1'b0;
        calm = 1'b0;

        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0 && pending_answers.size() == 0) begin
            $display("[postfix_expression_evaluator] OK");
        end else begin
            $display("[postfix_expression_evaluator] ERROR");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side. Ready changes on the falling edge; each result
    // transaction is compared with the oldest expectation.
    // ------------------------------------------------------------------------
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_if.ready <= !take_break();
        end
    end

    always @(posedge i_clk) begin
        t_expr_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_answers.size() == 0) begin
                $error("result with nothing expected: answer %0d, status %0d",
                       res_if.answer, res_if.status);
                failures++;
            end else begin
                want = pending_answers.pop_front();
                if (res_if.answer !== want.answer) begin
                    $error("answer: expected %0d, actual %0d", want.answer, res_if.answer);
                    failures++;
                end
                if (res_if.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, res_if.status);
                    failures++;
                end
            end
        end
    end

endmodule
